// File: design/assert_macros.svh
// Assertion macros used by the delay line unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define FDL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after its trigger.
`define FDL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: design/fdl_pkg.sv
// Types, constants and helper functions of the fractional delay line.
package fdl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int DELAY_BITS  = 16;
  localparam int SPM_BITS    = 24;
  localparam int BLEN_BITS   = 13;
  localparam int CFG_BITS    = 24;
  localparam int MAX_DEPTH   = 4096;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_LINEAR  = 2'd1,
    CMD_HERMITE = 2'd2
  } cmd_e;

  localparam logic CFG_BUFFER_LENGTH  = 1'b0;
  localparam logic CFG_SAMPLES_PER_MS = 1'b1;

  // Smoothing step: |diff| / 2500 through a reciprocal, the tanh argument saturates at 1.0.
  localparam int unsigned STEP_DIV    = 2500;
  localparam int unsigned TANH_SAT_U  = 163840000;
  localparam longint unsigned RECIP_2500 = 64'd439804651;

  // tanh(k/16) in Q0.16; entries beyond the table hold the last value.
  function automatic logic [15:0] tanh_lut(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd4091;
      5'd2:  v = 16'd8150;
      5'd3:  v = 16'd12146;
      5'd4:  v = 16'd16051;
      5'd5:  v = 16'd19838;
      5'd6:  v = 16'd23485;
      5'd7:  v = 16'd26973;
      5'd8:  v = 16'd30285;
      5'd9:  v = 16'd33412;
      5'd10: v = 16'd36346;
      5'd11: v = 16'd39084;
      5'd12: v = 16'd41625;
      5'd13: v = 16'd43972;
      5'd14: v = 16'd46131;
      5'd15: v = 16'd48108;
      default: v = 16'd49912;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the sample range.
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd2 ** (SAMPLE_BITS - 1) - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// File: design/fractional_delay_line_unit.sv
// Fractional delay line: ring memory with smoothed linear and direct Hermite read taps.
// A sample write leaves the block in its idle state, so it is ready again in the next cycle.
// Both read kinds run through sequencer states from the input transfer to a valid result,
// set by the single read port of the ring memory, the divide and tanh steps and the shared
// Horner step; no new input transfer is taken until the result is loaded, and a full result register adds stalls.
// After reset and every buffer_length write, a clearing pass over all MAX_DEPTH entries refuses all input.
module fractional_delay_line_unit
  import fdl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [39:0]            s_axis_tdata,   // sample_in [23:0], delay_ms [39:24]
  input  logic [1:0]             s_axis_tuser,   // cmd [1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // sample_out [23:0]
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CFG_BITS-1:0]    cfg_data_i
);

`include "assert_macros.svh"

  // Address width, width able to hold the length itself, and position widths.
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int PW = AW + FRAC_BITS;
  localparam int FW = LW + FRAC_BITS;
  localparam int SW = FW + 2;
  localparam int CW = (FW > 32) ? FW + 1 : 33;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL, S_TAP, S_DIFF, S_DIV1, S_DIV2, S_TANH, S_STEP,
    S_L0, S_L1, S_L2, S_H0, S_H1, S_H2, S_H3, S_H4, S_M1, S_M2, S_M3
  } st_e;

  st_e                     state_q;
  logic [BLEN_BITS-1:0]    blen_q;
  logic [SPM_BITS-1:0]     spm_q;
  logic [AW-1:0]           wp_q;
  logic [PW-1:0]           rp_q;
  logic [AW-1:0]           clr_q;
  logic                    out_valid_q;
  logic [SAMPLE_BITS-1:0]  out_q;

  // Payload registers of the sequencer.
  cmd_e                    cmd_q;
  logic [DELAY_BITS-1:0]   delay_q;
  logic [31:0]             d_q;
  logic [PW-1:0]           pos_q;
  logic signed [SW-1:0]    diff_q;
  logic [27:0]             u_q;
  logic                    sat_q;
  logic                    neg_q;
  logic [15:0]             qe_q;
  logic [15:0]             x_q;
  logic [15:0]             th_q;
  logic [SAMPLE_BITS-1:0]  b0_q;
  logic [SAMPLE_BITS-1:0]  pa_q;
  logic [SAMPLE_BITS-1:0]  pb_q;
  logic [SAMPLE_BITS-1:0]  pc_q;
  logic signed [31:0]      ca_q;
  logic signed [31:0]      cb_q;
  logic signed [31:0]      cc_q;
  logic signed [31:0]      cd_q;
  logic signed [31:0]      acc_q;

  // Ring memory with one write and one registered read port.
  logic [SAMPLE_BITS-1:0]  ring_mem [MAX_DEPTH];
  logic [SAMPLE_BITS-1:0]  mem_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [SAMPLE_BITS-1:0]  mem_wdata;
  logic [AW-1:0]           mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= ring_mem[mem_raddr];
  end

  // Active length, clamped to the supported range.
  logic [LW-1:0] len;
  logic [FW-1:0] full;
  logic [FW-1:0] half;
  logic [AW-1:0] wp_eff;
  logic [PW-1:0] rp_eff;

  always_comb begin
    if (32'(blen_q) < 32'd4) begin
      len = LW'(4);
    end else if (32'(blen_q) > 32'(MAX_DEPTH)) begin
      len = LW'(MAX_DEPTH);
    end else begin
      len = LW'(blen_q);
    end
    full   = FW'(len) << FRAC_BITS;
    half   = FW'(len) << (FRAC_BITS - 1);
    wp_eff = (32'(wp_q) < 32'(len)) ? wp_q : '0;
    rp_eff = (FW'(rp_q) >= full) ? '0 : rp_q;
  end

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The result register takes a new value when it is empty or drained in this cycle.
  logic out_free;
  logic out_load;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = out_free && ((state_q == S_L2) || (state_q == S_M3));

  // Tap position: write pointer minus the delay, saturated at length minus one.
  logic [39:0]          dprod;
  logic [FW-1:0]        lim;
  logic [FW-1:0]        dclamp;
  logic signed [SW-1:0] pos_s;

  always_comb begin
    dprod = 40'(delay_q) * 40'(spm_q);
    lim   = FW'(len - LW'(1)) << FRAC_BITS;
    if (CW'(d_q) > CW'(lim)) begin
      dclamp = lim;
    end else begin
      dclamp = FW'(d_q);
    end
    pos_s = SW'({wp_eff, {FRAC_BITS{1'b0}}}) - SW'(dclamp);
    if (pos_s < 0) begin
      pos_s = pos_s + SW'(full);
    end
  end

  // Distance to the tap, wrapped into plus or minus half the ring.
  logic signed [SW-1:0] full_s;
  logic signed [SW-1:0] half_s;
  logic signed [SW-1:0] diff_s;
  logic [SW-1:0]        u_abs;

  always_comb begin
    full_s = $signed(SW'(full));
    half_s = $signed(SW'(half));
    diff_s = $signed(SW'(pos_q)) - $signed(SW'(rp_eff));
    if (diff_s > half_s) begin
      diff_s = diff_s - full_s;
    end else if (diff_s < -half_s) begin
      diff_s = diff_s + full_s;
    end
    u_abs = (diff_q < 0) ? SW'(-diff_q) : SW'(diff_q);
  end

  // Division by 2500 through a reciprocal; the estimate is low by at most one.
  logic [56:0] qprod;
  logic [29:0] rem;

  always_comb begin
    qprod = 57'(u_abs[27:0]) * 57'(RECIP_2500);
    rem   = 30'(u_q) - 30'(qe_q) * 30'(STEP_DIV);
  end

  // tanh by table and linear interpolation, then the step 2.5*tanh.
  logic [15:0]          t0;
  logic [15:0]          t1;
  logic [27:0]          tprod;
  logic [18:0]          st;
  logic signed [SW-1:0] rp_n;

  always_comb begin
    t0    = tanh_lut({1'b0, x_q[15:12]});
    t1    = tanh_lut({1'b0, x_q[15:12]} + 5'd1);
    tprod = 28'(t1 - t0) * 28'(x_q[11:0]);
    st    = (19'(th_q) * 19'd5) >> 1;
    if (neg_q) begin
      rp_n = $signed(SW'(rp_eff)) - $signed(SW'(st));
    end else begin
      rp_n = $signed(SW'(rp_eff)) + $signed(SW'(st));
    end
    if (rp_n < 0) begin
      rp_n = rp_n + full_s;
    end else if (rp_n >= full_s) begin
      rp_n = rp_n - full_s;
    end
  end

  // Neighbour addresses around the tap, all modulo the active length.
  logic [AW-1:0]        tap_idx;
  logic [FRAC_BITS-1:0] tap_frac;
  logic [AW-1:0]        idx_m1;
  logic [AW-1:0]        idx_p1;
  logic [AW-1:0]        idx_p2;
  logic [LW:0]          sum1;
  logic [LW:0]          sum2;

  always_comb begin
    if (cmd_q == CMD_LINEAR) begin
      tap_idx  = rp_q[PW-1:FRAC_BITS];
      tap_frac = rp_q[FRAC_BITS-1:0];
    end else begin
      tap_idx  = pos_q[PW-1:FRAC_BITS];
      tap_frac = pos_q[FRAC_BITS-1:0];
    end
    sum1   = (LW+1)'(tap_idx) + (LW+1)'(1);
    sum2   = (LW+1)'(tap_idx) + (LW+1)'(2);
    idx_m1 = (tap_idx == '0) ? AW'(len - LW'(1)) : tap_idx - AW'(1);
    idx_p1 = (sum1 >= (LW+1)'(len)) ? AW'(sum1 - (LW+1)'(len)) : AW'(sum1);
    idx_p2 = (sum2 >= (LW+1)'(len)) ? AW'(sum2 - (LW+1)'(len)) : AW'(sum2);
  end

  // Linear interpolation between two neighbours.
  logic signed [24:0] ldiff;
  logic signed [41:0] lprod;
  logic signed [31:0] lsum;

  always_comb begin
    ldiff = $signed({mem_q[SAMPLE_BITS-1], mem_q}) - $signed({b0_q[SAMPLE_BITS-1], b0_q});
    lprod = 42'(ldiff) * $signed({1'b0, tap_frac});
    lsum  = 32'($signed(b0_q)) + 32'($signed(lprod[41:16]));
  end

  // Catmull-Rom coefficients (doubled) and one shared Horner step.
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [31:0] p3;
  logic signed [31:0] h_in;
  logic signed [31:0] h_add;
  logic signed [48:0] hprod;
  logic signed [31:0] h_res;

  always_comb begin
    p0 = 32'($signed(pa_q));
    p1 = 32'($signed(pb_q));
    p2 = 32'($signed(pc_q));
    p3 = 32'($signed(mem_q));
    h_in  = (state_q == S_M1) ? ca_q : acc_q;
    case (state_q)
      S_M1:    h_add = cb_q;
      S_M2:    h_add = cc_q;
      default: h_add = cd_q;
    endcase
    hprod = 49'(h_in) * $signed({1'b0, tap_frac});
    h_res = $signed(hprod[47:16]) + h_add;
  end

  // Memory port selection. While the linear result waits for the output register the
  // upper neighbour stays addressed so that the read data does not change.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_eff;
    mem_wdata = s_axis_tdata[SAMPLE_BITS-1:0];
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (accept && (s_axis_tuser == CMD_WRITE)) begin
      mem_we = 1'b1;
    end
    case (state_q)
      S_L0:    mem_raddr = tap_idx;
      S_L1:    mem_raddr = idx_p1;
      S_L2:    mem_raddr = idx_p1;
      S_H0:    mem_raddr = idx_m1;
      S_H1:    mem_raddr = tap_idx;
      S_H2:    mem_raddr = idx_p1;
      S_H3:    mem_raddr = idx_p2;
      default: mem_raddr = tap_idx;
    endcase
  end

  // Sequencer, pointers, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      blen_q      <= BLEN_BITS'(4096);
      spm_q       <= SPM_BITS'(3145728);
      wp_q        <= '0;
      rp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_index_i == CFG_SAMPLES_PER_MS)) begin
        spm_q <= cfg_data_i[SPM_BITS-1:0];
      end
      if (cfg_we_i && (cfg_index_i == CFG_BUFFER_LENGTH)) begin
        // A new length restarts the ring from empty.
        blen_q  <= cfg_data_i[BLEN_BITS-1:0];
        wp_q    <= '0;
        rp_q    <= '0;
        clr_q   <= '0;
        state_q <= S_CLEAR;
      end else begin
        case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + AW'(1);
            if (clr_q == AW'(MAX_DEPTH - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              case (s_axis_tuser)
                CMD_WRITE: begin
                  if (32'(wp_eff) + 32'd1 >= 32'(len)) begin
                    wp_q <= '0;
                  end else begin
                    wp_q <= wp_eff + AW'(1);
                  end
                end
                CMD_LINEAR, CMD_HERMITE: state_q <= S_MUL;
                default: state_q <= S_IDLE;
              endcase
            end
          end
          S_MUL:  state_q <= S_TAP;
          S_TAP:  state_q <= (cmd_q == CMD_LINEAR) ? S_DIFF : S_H0;
          S_DIFF: state_q <= S_DIV1;
          S_DIV1: state_q <= S_DIV2;
          S_DIV2: state_q <= S_TANH;
          S_TANH: state_q <= S_STEP;
          S_STEP: begin
            rp_q    <= rp_n[PW-1:0];
            state_q <= S_L0;
          end
          S_L0: state_q <= S_L1;
          S_L1: state_q <= S_L2;
          S_L2: begin
            if (out_free) begin
              out_q   <= sat_sample(lsum);
              state_q <= S_IDLE;
            end
          end
          S_H0: state_q <= S_H1;
          S_H1: state_q <= S_H2;
          S_H2: state_q <= S_H3;
          S_H3: state_q <= S_H4;
          S_H4: state_q <= S_M1;
          S_M1: state_q <= S_M2;
          S_M2: state_q <= S_M3;
          S_M3: begin
            if (out_free) begin
              out_q   <= sat_sample(h_res >>> 1);
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  // Datapath registers of the sequencer steps.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      delay_q <= s_axis_tdata[39:24];
    end
    case (state_q)
      S_MUL:  d_q    <= dprod[39:8];
      S_TAP:  pos_q  <= pos_s[PW-1:0];
      S_DIFF: diff_q <= diff_s;
      S_DIV1: begin
        u_q   <= u_abs[27:0];
        sat_q <= (32'(u_abs) >= TANH_SAT_U);
        neg_q <= (diff_q < 0);
        qe_q  <= qprod[55:40];
      end
      S_DIV2: x_q  <= (rem >= 30'(STEP_DIV)) ? qe_q + 16'd1 : qe_q;
      S_TANH: th_q <= sat_q ? tanh_lut(5'd16) : t0 + 16'(tprod >> 12);
      S_L1:   b0_q <= mem_q;
      S_H1:   pa_q <= mem_q;
      S_H2:   pb_q <= mem_q;
      S_H3:   pc_q <= mem_q;
      S_H4: begin
        ca_q <= -p0 + 32'sd3 * p1 - 32'sd3 * p2 + p3;
        cb_q <= 32'sd2 * p0 - 32'sd5 * p1 + 32'sd4 * p2 - p3;
        cc_q <= p2 - p0;
        cd_q <= 32'sd2 * p1;
      end
      S_M1, S_M2: acc_q <= h_res;
      default: acc_q <= acc_q;
    endcase
  end

  `FDL_ASSERT(a_no_accept_busy, !s_axis_tready || (state_q == S_IDLE), "input taken while busy")
  `FDL_ASSERT_NEXT(a_wp_in_ring, accept && (s_axis_tuser == CMD_WRITE), 32'(wp_q) < 32'(len), "write pointer left the ring")
  `FDL_ASSERT(a_rp_in_ring, (state_q != S_IDLE) || (FW'(rp_q) < full), "read position left the ring")

endmodule

// File: tb/sv/fractional_delay_line_checker.sv
// Checker of the fractional delay line: predicts each read result and compares it.
module fractional_delay_line_checker
  import fdl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [39:0]            s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [SAMPLE_BITS-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CFG_BITS-1:0]    cfg_data_i,
  output int                     pending_o,
  output int                     errors_o
);

  localparam int RING_DEPTH = 4096;
  localparam longint TANH_Q16 [0:16] = '{0, 4091, 8150, 12146, 16051, 19838, 23485,
    26973, 30285, 33412, 36346, 39084, 41625, 43972, 46131, 48108, 49912};

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  longint unsigned        wr_ptr;
  longint                 glide_pos;
  longint unsigned        ring_len_reg;
  longint unsigned        rate_reg;
  logic [SAMPLE_BITS-1:0] sample_q [$];
  int                     errors;

  function automatic longint unsigned active_len();
    if (ring_len_reg < 4) return 4;
    if (ring_len_reg > RING_DEPTH) return RING_DEPTH;
    return ring_len_reg;
  endfunction

  function automatic longint tap_sample(longint unsigned idx, longint unsigned len);
    logic signed [SAMPLE_BITS-1:0] v;
    v = ring[idx % len];
    return longint'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Tap point (write pointer minus delay) with 16 fraction bits, wrapped into the ring.
  function automatic longint tap_point(logic [15:0] delay, longint unsigned len);
    longint unsigned d;
    longint unsigned lim;
    longint unsigned wp;
    longint          pos;
    d   = (longint'(delay) * rate_reg) >> 8;
    lim = (len - 1) << FRAC_BITS;
    wp  = (wr_ptr < len) ? wr_ptr : 0;
    if (d > lim) d = lim;
    pos = longint'(wp << FRAC_BITS) - longint'(d);
    if (pos < 0) pos += longint'(len << FRAC_BITS);
    return pos;
  endfunction

  function automatic longint glide_step(longint diff);
    longint unsigned u;
    longint unsigned x;
    longint unsigned k;
    longint          th;
    longint          st;
    u = (diff < 0) ? -diff : diff;
    x = u / 2500;
    if (x >= 65536) begin
      th = TANH_Q16[16];
    end else begin
      k  = x >> 12;
      th = TANH_Q16[k] + (((TANH_Q16[k+1] - TANH_Q16[k]) * longint'(x & 4095)) >>> 12);
    end
    st = (th * 5) >>> 1;
    return (diff < 0) ? -st : st;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] smoothed_sample(logic [15:0] delay);
    longint unsigned len;
    longint          full;
    longint          half;
    longint          rp;
    longint          diff;
    longint          f;
    longint          b0;
    longint          b1;
    len  = active_len();
    full = longint'(len << FRAC_BITS);
    half = longint'(len << (FRAC_BITS - 1));
    rp   = glide_pos;
    if (rp >= full) rp = 0;
    diff = tap_point(delay, len) - rp;
    if (diff > half) diff -= full;
    if (diff < -half) diff += full;
    rp += glide_step(diff);
    if (rp < 0) rp += full;
    if (rp >= full) rp -= full;
    glide_pos = rp;
    f  = rp & 64'hFFFF;
    b0 = tap_sample(rp >> FRAC_BITS, len);
    b1 = tap_sample((rp >> FRAC_BITS) + 1, len);
    return clamp_sample(b0 + (((b1 - b0) * f) >>> FRAC_BITS));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] hermite_sample(logic [15:0] delay);
    longint unsigned len;
    longint          pos;
    longint unsigned i1;
    longint          t;
    longint          p0, p1, p2, p3;
    longint          acc;
    len = active_len();
    pos = tap_point(delay, len);
    i1  = pos >> FRAC_BITS;
    t   = pos & 64'hFFFF;
    p0  = tap_sample(i1 + len - 1, len);
    p1  = tap_sample(i1, len);
    p2  = tap_sample(i1 + 1, len);
    p3  = tap_sample(i1 + 2, len);
    // Horner on doubled Catmull-Rom coefficients, halved at the end.
    acc = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = ((acc * t) >>> FRAC_BITS) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
    acc = ((acc * t) >>> FRAC_BITS) + (p2 - p0);
    acc = ((acc * t) >>> FRAC_BITS) + 2 * p1;
    return clamp_sample(acc >>> 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SAMPLE_BITS-1:0] want;
    longint unsigned        len;
    if (!rst_ni) begin
      foreach (ring[i]) ring[i] = '0;
      wr_ptr       = 0;
      glide_pos    = 0;
      ring_len_reg = 4096;
      rate_reg     = 3145728;
      sample_q.delete();
      errors       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $error("sample_out: unexpected result %0h", m_axis_tdata);
          errors++;
        end else begin
          want = sample_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("sample_out: expected %0h, actual %0h", want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_BUFFER_LENGTH) begin
          ring_len_reg = cfg_data_i[BLEN_BITS-1:0];
          foreach (ring[i]) ring[i] = '0;
          wr_ptr    = 0;
          glide_pos = 0;
        end else begin
          rate_reg = cfg_data_i[SPM_BITS-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_WRITE: begin
            len = active_len();
            if (wr_ptr >= len) wr_ptr = 0;
            ring[wr_ptr] = s_axis_tdata[23:0];
            wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
          end
          CMD_LINEAR:  sample_q.push_back(smoothed_sample(s_axis_tdata[39:24]));
          CMD_HERMITE: sample_q.push_back(hermite_sample(s_axis_tdata[39:24]));
          default: ;
        endcase
      end
    end
    pending_o <= sample_q.size();
    errors_o  <= errors;
  end

endmodule

// File: tb/sv/fractional_delay_line_unit_test.sv
// Top of the fractional delay line testbench: stimulus, handshakes and the verdict.
module fractional_delay_line_unit_test;
  import fdl_pkg::*;

  // Settings visited in turn; the first keeps the reset values of both registers.
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 260;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_BITS-1:0] LEN_SET [NUM_PHASES] =
    '{24'd4096, 24'd4, 24'd0, 24'd8191, 24'd37, 24'd4096};
  localparam logic [CFG_BITS-1:0] RATE_SET [NUM_PHASES] =
    '{24'd3145728, 24'd16777215, 24'd0, 24'd65536, 24'd12345678, 24'd3145728};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [39:0]            s_axis_tdata;   // sample_in [23:0], delay_ms [39:24]
  logic [1:0]             s_axis_tuser;   // cmd [1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;   // sample_out [23:0]
  logic                   cfg_we_i;
  logic                   cfg_index_i;
  logic [CFG_BITS-1:0]    cfg_data_i;
  int                     pending;
  int                     errors;
  int                     quiet_cycles;

  fractional_delay_line_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  fractional_delay_line_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offers one item, waits for the edge of its transfer, then idles for the gap before returning.
  // The valid is only dropped when a gap follows, so back-to-back items keep it high.
  task automatic offer_item(input cmd_e op, input logic [23:0] smp, input logic [15:0] dly,
                            input int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {dly, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits with the input quiet until every result is back, then lets the
  // sequencer run out its latency so that nothing is in flight.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_e pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CMD_WRITE;
    if (r < 72) return CMD_LINEAR;
    if (r < 94) return CMD_HERMITE;
    return cmd_e'(2'd3);
  endfunction

  // Stimulus: reset, a directed opening on the reset settings, then random phases.
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads of the freshly cleared ring, then the extremes of every field.
    offer_item(CMD_LINEAR,  24'h000000, 16'd0,     0);
    offer_item(CMD_HERMITE, 24'h000000, 16'hFFFF,  1);
    offer_item(CMD_WRITE,   24'h7FFFFF, 16'hFFFF,  0);
    offer_item(CMD_WRITE,   24'h800000, 16'h0000,  0);
    offer_item(CMD_WRITE,   24'h7FFFFF, 16'h0000,  0);
    offer_item(CMD_WRITE,   24'h800000, 16'h0000,  0);
    offer_item(CMD_WRITE,   24'h7FFFFF, 16'h0000,  0);
    offer_item(CMD_HERMITE, 24'hFFFFFF, 16'd3,     0);
    offer_item(CMD_HERMITE, 24'h000000, 16'd7,     2);
    offer_item(CMD_LINEAR,  24'h000000, 16'd5,     0);
    offer_item(CMD_LINEAR,  24'h000000, 16'hFFFF,  0);
    offer_item(cmd_e'(2'd3), 24'hFFFFFF, 16'hFFFF, 0);
    offer_item(CMD_HERMITE, 24'h000000, 16'd0,     0);
    offer_item(CMD_HERMITE, 24'h000000, 16'hFFFF,  0);
    offer_item(CMD_WRITE,   24'h000000, 16'hFFFF,  0);
    offer_item(CMD_LINEAR,  24'h000000, 16'd1,     0);
    offer_item(CMD_HERMITE, 24'h000000, 16'd1,     3);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        // Rate first: the length write clears the ring and both pointers.
        write_reg(CFG_SAMPLES_PER_MS, RATE_SET[ph]);
        write_reg(CFG_BUFFER_LENGTH, LEN_SET[ph]);
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through a phase the sender stops until the block has gone quiet.
        if (n == PHASE_ITEMS / 2) drain_results();
        // Long runs of writes first so that read taps land on filled entries.
        if (n < 40) offer_item(CMD_WRITE, pick_sample(), pick_delay(), sender_gap());
        else offer_item(pick_cmd(), pick_sample(), pick_delay(), sender_gap());
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, mostly short, with one long hold-off that lets the
  // block fill up and refuse further input transfers. The hold-off starts while a result is
  // waiting, after more than 20 rounds since the first input transfer after the clearing pass.
  initial begin
    int rounds;
    int gap;
    int r;
    bit held;
    rounds = 0;
    held   = 1'b0;
    m_axis_tready = 1'b0;
    do @(posedge clk_i); while (!(rst_ni && s_axis_tvalid && s_axis_tready));
    forever begin
      rounds++;
      r = $urandom_range(0, 99);
      if (!held && (rounds > 20) && m_axis_tvalid) begin
        gap  = 400;
        held = 1'b1;
      end
      else if (r < 60) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 50);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? 60 : $urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Watchdog over cycles with no transfer on either side; allows the clearing pass.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
